### rtl/core/plint_pkg.sv
// Package for the piecewise-linear interpolator: widths, register indexes,
// status codes, reset values, pipeline stage records and the divider step.
// No dependencies.
`default_nettype none

package plint_pkg;

  localparam int XW        = 16;          // sample and breakpoint x width
  localparam int SW        = 24;          // Q8.16 score width
  localparam int STW       = 2;           // status width
  localparam int AW        = 3;           // config index width
  localparam int DW        = 24;          // config data width
  localparam int PW        = XW + SW;     // product magnitude width
  localparam int DIV_STEPS = SW;          // one quotient bit per stage
  localparam int NUM_STAGES = DIV_STEPS + 4;

  typedef enum logic [STW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NOSEG = 2'd2
  } status_e;

  typedef enum logic [AW-1:0] {
    REG_COUNT = 3'd0,
    REG_X0    = 3'd1,
    REG_X1    = 3'd2,
    REG_X2    = 3'd3,
    REG_S0    = 3'd4,
    REG_S1    = 3'd5,
    REG_S2    = 3'd6
  } reg_e;

  localparam logic [1:0]    RST_COUNT = 2'd3;
  localparam logic [XW-1:0] RST_X0    = 16'd0;
  localparam logic [XW-1:0] RST_X1    = 16'd60;
  localparam logic [XW-1:0] RST_X2    = 16'd500;
  localparam logic [SW-1:0] RST_S0    = 24'd65536;
  localparam logic [SW-1:0] RST_S1    = 24'd65536;
  localparam logic [SW-1:0] RST_S2    = 24'd0;

  // segment select result
  typedef struct packed {
    status_e         status;
    logic [SW-1:0]   base;
    logic [XW-1:0]   dx;
    logic [SW:0]     dy;
    logic [XW-1:0]   dvs;
  } sel_t;

  // sign split
  typedef struct packed {
    status_e         status;
    logic [SW-1:0]   base;
    logic [XW-1:0]   dx;
    logic [SW-1:0]   mag;
    logic            neg;
    logic [XW-1:0]   dvs;
  } mag_t;

  // product
  typedef struct packed {
    status_e         status;
    logic [SW-1:0]   base;
    logic [PW-1:0]   prod;
    logic            neg;
    logic [XW-1:0]   dvs;
  } mul_t;

  // one restoring-division stage; lo shifts dividend bits out, quotient bits in
  typedef struct packed {
    status_e         status;
    logic [SW-1:0]   base;
    logic            neg;
    logic [XW-1:0]   dvs;
    logic [XW-1:0]   rem;
    logic [SW-1:0]   lo;
  } div_t;

  function automatic div_t div_step(div_t a);
    logic [XW:0] t;
    logic        ge;
    div_t        r;
    t  = {a.rem, a.lo[SW-1]};
    ge = (t >= {1'b0, a.dvs});
    r  = a;
    r.rem = ge ? XW'(t - {1'b0, a.dvs}) : t[XW-1:0];
    r.lo  = {a.lo[SW-2:0], ge};
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/piecewise_linear_interpolator.sv
// Piecewise-linear interpolator top level: segment select, multiply and a
// pipelined restoring divider. Depends on plint_pkg.
//
// Maps each 16-bit sample through a curve of up to three breakpoints and
// returns a signed Q8.16 score plus a status code. One sample enters per
// clock unless the full pipeline is stalled at the output. Stages: one for
// segment select, one for sign split, one for the 16x24 multiply, 24 stages
// of the one-bit-per-stage quotient pipeline and the output register. Empty
// stages close up under back-pressure, so input keeps flowing while a result
// waits. Index 7 is ignored. Breakpoints are written through the config
// port; the user must do so only while idle; the block does not check.
`default_nettype none

module piecewise_linear_interpolator (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // config write channel
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [plint_pkg::AW-1:0] cfg_addr_i,
  input  wire logic [plint_pkg::DW-1:0] cfg_data_i,
  // sample stream
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [15:0]              s_axis_tdata,   // [15:0] sample_x
  // result stream
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic [23:0]                   m_axis_tdata,   // [23:0] curve_score
  output logic [1:0]                    m_axis_tuser    // [1:0] status
);

  localparam int NS    = plint_pkg::NUM_STAGES;
  localparam int S_SEL = 0;
  localparam int S_MAG = 1;
  localparam int S_MUL = 2;
  localparam int S_DV0 = 3;
  localparam int S_OUT = NS - 1;
  localparam int ND    = plint_pkg::DIV_STEPS;
  localparam int XW    = plint_pkg::XW;
  localparam int SW    = plint_pkg::SW;

  // ---------------- configuration ----------------
  logic [1:0]    cnt_q;
  logic [XW-1:0] x0_q, x1_q, x2_q;
  logic [SW-1:0] s0_q, s1_q, s2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= plint_pkg::RST_COUNT;
      x0_q  <= plint_pkg::RST_X0;
      x1_q  <= plint_pkg::RST_X1;
      x2_q  <= plint_pkg::RST_X2;
      s0_q  <= plint_pkg::RST_S0;
      s1_q  <= plint_pkg::RST_S1;
      s2_q  <= plint_pkg::RST_S2;
    end else if (cfg_valid_i) begin
      unique case (plint_pkg::reg_e'(cfg_addr_i))
        plint_pkg::REG_COUNT: cnt_q <= cfg_data_i[1:0];
        plint_pkg::REG_X0:    x0_q  <= cfg_data_i[XW-1:0];
        plint_pkg::REG_X1:    x1_q  <= cfg_data_i[XW-1:0];
        plint_pkg::REG_X2:    x2_q  <= cfg_data_i[XW-1:0];
        plint_pkg::REG_S0:    s0_q  <= cfg_data_i[SW-1:0];
        plint_pkg::REG_S1:    s1_q  <= cfg_data_i[SW-1:0];
        plint_pkg::REG_S2:    s2_q  <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage flow control ----------------
  logic [NS-1:0] vld_q, vld_d, adv;

  always_comb begin
    adv[S_OUT] = !vld_q[S_OUT] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (adv[k]) begin
        vld_d[k] = (k == 0) ? s_axis_tvalid : vld_q[(k == 0) ? 0 : k-1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = adv[S_SEL];

  // ---------------- segment select ----------------
  logic [XW-1:0]      x;
  logic [XW-1:0]      xl;
  logic [SW-1:0]      sl;
  logic [XW-1:0]      xa, xb;
  logic [SW-1:0]      sa, sb;
  logic               seg_ok;
  plint_pkg::sel_t    sel_d, sel_q;

  assign x = s_axis_tdata[XW-1:0];

  always_comb begin
    unique case (cnt_q)
      2'd2:    begin xl = x1_q; sl = s1_q; end
      2'd3:    begin xl = x2_q; sl = s2_q; end
      default: begin xl = x0_q; sl = s0_q; end
    endcase
  end

  // first segment with xa < x <= xb; x > x0 is already known on this path
  always_comb begin
    xa = x0_q; xb = x1_q; sa = s0_q; sb = s1_q;
    seg_ok = 1'b0;
    priority if (cnt_q >= 2'd2 && x <= x1_q) begin
      seg_ok = 1'b1;
    end else if (cnt_q == 2'd3 && x > x1_q && x <= x2_q) begin
      xa = x1_q; xb = x2_q; sa = s1_q; sb = s2_q;
      seg_ok = 1'b1;
    end else begin
      seg_ok = 1'b0;
    end
  end

  always_comb begin
    sel_d.status = plint_pkg::ST_OK;
    sel_d.base   = '0;
    sel_d.dx     = '0;
    sel_d.dy     = '0;
    sel_d.dvs    = XW'(1);  // zero dividend with unit divisor gives zero quotient
    priority if (cnt_q == 2'd0) begin
      sel_d.status = plint_pkg::ST_EMPTY;
    end else if (x <= x0_q) begin
      sel_d.base = s0_q;
    end else if (x >= xl) begin
      sel_d.base = sl;
    end else if (seg_ok) begin
      sel_d.base = sa;
      sel_d.dx   = x - xa;
      sel_d.dy   = {sb[SW-1], sb} - {sa[SW-1], sa};
      sel_d.dvs  = xb - xa;
    end else begin
      sel_d.status = plint_pkg::ST_NOSEG;
    end
  end

  // ---------------- sign split and multiply ----------------
  plint_pkg::mag_t mag_d, mag_q;
  plint_pkg::mul_t mul_d, mul_q;
  logic [SW:0]     dy_abs;

  always_comb begin
    dy_abs       = sel_q.dy[SW] ? -sel_q.dy : sel_q.dy;
    mag_d.status = sel_q.status;
    mag_d.base   = sel_q.base;
    mag_d.dx     = sel_q.dx;
    mag_d.mag    = dy_abs[SW-1:0];
    mag_d.neg    = sel_q.dy[SW];
    mag_d.dvs    = sel_q.dvs;
  end

  always_comb begin
    mul_d.status = mag_q.status;
    mul_d.base   = mag_q.base;
    mul_d.prod   = {{SW{1'b0}}, mag_q.dx} * {{XW{1'b0}}, mag_q.mag};
    mul_d.neg    = mag_q.neg;
    mul_d.dvs    = mag_q.dvs;
  end

  // ---------------- quotient pipeline ----------------
  // |dx*dy| < dvs * 2^24, so the top 16 bits already sit below the divisor
  plint_pkg::div_t div_in;
  plint_pkg::div_t div_q [ND];

  always_comb begin
    div_in.status = mul_q.status;
    div_in.base   = mul_q.base;
    div_in.neg    = mul_q.neg;
    div_in.dvs    = mul_q.dvs;
    div_in.rem    = mul_q.prod[plint_pkg::PW-1:SW];
    div_in.lo     = mul_q.prod[SW-1:0];
  end

  // ---------------- output ----------------
  logic [SW-1:0] quo_s;
  logic [SW-1:0] score_q;
  logic [1:0]    status_q;

  assign quo_s = div_q[ND-1].neg ? -div_q[ND-1].lo : div_q[ND-1].lo;

  always_ff @(posedge clk_i) begin
    if (adv[S_SEL]) sel_q <= sel_d;
    if (adv[S_MAG]) mag_q <= mag_d;
    if (adv[S_MUL]) mul_q <= mul_d;
    if (adv[S_DV0]) div_q[0] <= plint_pkg::div_step(div_in);
    for (int k = 1; k < ND; k++) begin
      if (adv[S_DV0 + k]) div_q[k] <= plint_pkg::div_step(div_q[k-1]);
    end
    if (adv[S_OUT]) begin
      score_q  <= div_q[ND-1].base + quo_s;
      status_q <= div_q[ND-1].status;
    end
  end

  assign m_axis_tvalid = vld_q[S_OUT];
  assign m_axis_tdata  = score_q;
  assign m_axis_tuser  = status_q;

  // ---------------- assertions ----------------
  a_dvs_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[S_DV0] |-> div_q[0].dvs != '0)
    else $error("divisor zero in quotient pipeline");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[S_OUT-1] |-> div_q[ND-1].rem < div_q[ND-1].dvs)
    else $error("remainder not below divisor");

  a_err_no_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[S_MUL] && mul_q.status != plint_pkg::ST_OK) |->
      (mul_q.prod == '0 && mul_q.base == '0))
    else $error("error item carries a product or base");

  a_err_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == plint_pkg::ST_EMPTY ||
                       m_axis_tuser == plint_pkg::ST_NOSEG)) |->
      m_axis_tdata == '0)
    else $error("error result with nonzero score");

endmodule

`default_nettype wire

### dv/tb_piecewise_linear_interpolator.sv
// Self-checking testbench for piecewise_linear_interpolator: breakpoint setups through the
// config channel, samples on the input stream, results checked against a local curve model.
// Depends on plint_pkg and the interpolator RTL.
module tb_piecewise_linear_interpolator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [plint_pkg::AW-1:0] REG_UNUSED = 3'd7;  // no register behind it
  localparam int                       IDLE_PCT   = 12;
  localparam int                       TAIL_WAIT  = 40;    // pipeline is 28 deep

  typedef struct packed {
    logic [plint_pkg::SW-1:0] score;
    plint_pkg::status_e       status;
  } curve_result_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [plint_pkg::AW-1:0] cfg_addr_i    = '0;
  logic [plint_pkg::DW-1:0] cfg_data_i    = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [15:0]              s_axis_tdata  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [23:0]              m_axis_tdata;
  logic [1:0]               m_axis_tuser;

  // local copy of the curve registers
  logic [1:0]                      point_cnt;
  logic [plint_pkg::XW-1:0]        pt_x [3];
  logic signed [plint_pkg::SW-1:0] pt_s [3];

  logic [15:0]   sample_q [$];
  curve_result_t score_q  [$];
  curve_result_t want_result;
  int            error_count = 0;
  bit            calm        = 1'b0;  // no idling on either side while set

  piecewise_linear_interpolator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic curve_result_t curve_value(input logic [plint_pkg::XW-1:0] x);
    curve_result_t r;
    longint        xv, xa, xb, sa, sb, res;
    bit            hit;
    r.score  = '0;
    r.status = plint_pkg::ST_OK;
    hit      = 1'b0;
    xv       = longint'(x);
    if (point_cnt == 0) begin
      r.status = plint_pkg::ST_EMPTY;
    end else if (x <= pt_x[0]) begin
      r.score = pt_s[0];
    end else if (x >= pt_x[point_cnt - 1]) begin
      r.score = pt_s[point_cnt - 1];
    end else begin
      for (int i = 0; i + 1 < point_cnt; i++) begin
        xa = longint'(pt_x[i]);
        xb = longint'(pt_x[i + 1]);
        if (!hit && xv > xa && xv <= xb) begin
          sa  = longint'(pt_s[i]);
          sb  = longint'(pt_s[i + 1]);
          // SV integer division truncates toward zero
          res     = sa + ((xv - xa) * (sb - sa)) / (xb - xa);
          r.score = res[plint_pkg::SW-1:0];
          hit     = 1'b1;
        end
      end
      if (!hit) r.status = plint_pkg::ST_NOSEG;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // sample driver: expectation is formed when a word is accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) score_q.push_back(curve_value(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= sample_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (score_q.size() == 0) begin
          report_mismatch($sformatf("result with no sample pending: score=%h status=%0d",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          want_result = score_q.pop_front();
          if (m_axis_tdata !== want_result.score)
            report_mismatch($sformatf("curve_score %h, expected %h",
                                      m_axis_tdata, want_result.score));
          if (m_axis_tuser !== want_result.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      m_axis_tuser, want_result.status));
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic write_reg(input logic [plint_pkg::AW-1:0] idx,
                           input logic [plint_pkg::DW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      plint_pkg::REG_COUNT: point_cnt = data[1:0];
      plint_pkg::REG_X0:    pt_x[0]   = data[plint_pkg::XW-1:0];
      plint_pkg::REG_X1:    pt_x[1]   = data[plint_pkg::XW-1:0];
      plint_pkg::REG_X2:    pt_x[2]   = data[plint_pkg::XW-1:0];
      plint_pkg::REG_S0:    pt_s[0]   = data;
      plint_pkg::REG_S1:    pt_s[1]   = data;
      plint_pkg::REG_S2:    pt_s[2]   = data;
      default:              ;
    endcase
  endtask

  // writes every register; unused upper bits carry junk the block must drop
  task automatic set_curve(input logic [1:0] cnt,
                           input logic [plint_pkg::XW-1:0] x0, x1, x2,
                           input logic [plint_pkg::SW-1:0] s0, s1, s2);
    write_reg(plint_pkg::REG_COUNT, {22'($urandom), cnt});
    write_reg(plint_pkg::REG_X0, {8'($urandom), x0});
    write_reg(plint_pkg::REG_X1, {8'($urandom), x1});
    write_reg(plint_pkg::REG_X2, {8'($urandom), x2});
    write_reg(plint_pkg::REG_S0, s0);
    write_reg(plint_pkg::REG_S1, s1);
    write_reg(plint_pkg::REG_S2, s2);
    write_reg(REG_UNUSED, 24'($urandom));
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || s_axis_tvalid || score_q.size() != 0);
  endtask

  task automatic random_curve();
    logic [1:0]               cnt;
    logic [plint_pkg::XW-1:0] xs [3];
    logic [plint_pkg::XW-1:0] t;
    int                       pick;
    pick = $urandom_range(9);
    cnt  = (pick < 1) ? 2'd0 : (pick < 2) ? 2'd1 : (pick < 4) ? 2'd2 : 2'd3;
    if ($urandom_range(2) == 0) begin
      // tight segments: small divisors, dense breakpoints
      xs[0] = 16'($urandom);
      xs[1] = xs[0] + 16'($urandom_range(1, 20));
      xs[2] = xs[1] + 16'($urandom_range(1, 20));
    end else begin
      for (int i = 0; i < 3; i++) xs[i] = 16'($urandom);
    end
    if ($urandom_range(3) != 0) begin
      if (xs[0] > xs[1]) begin t = xs[0]; xs[0] = xs[1]; xs[1] = t; end
      if (xs[1] > xs[2]) begin t = xs[1]; xs[1] = xs[2]; xs[2] = t; end
      if (xs[0] > xs[1]) begin t = xs[0]; xs[0] = xs[1]; xs[1] = t; end
    end
    set_curve(cnt, xs[0], xs[1], xs[2], 24'($urandom), 24'($urandom), 24'($urandom));
  endtask

  task automatic random_samples(input int n);
    int                       mode;
    logic [plint_pkg::XW-1:0] x;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(9);
      if (mode < 4)
        x = 16'($urandom);
      else if (mode < 8)
        x = pt_x[$urandom_range(2)] + 16'($urandom_range(6)) - 16'd3;
      else
        x = 16'($urandom_range(pt_x[0], pt_x[2]));
      sample_q.push_back(x);
      // hold the sender at most once until the pipeline is empty
      if (i == n / 2 && mode == 0) wait_drained();
    end
  endtask

  initial begin
    point_cnt = plint_pkg::RST_COUNT;
    pt_x[0]   = plint_pkg::RST_X0;
    pt_x[1]   = plint_pkg::RST_X1;
    pt_x[2]   = plint_pkg::RST_X2;
    pt_s[0]   = plint_pkg::RST_S0;
    pt_s[1]   = plint_pkg::RST_S1;
    pt_s[2]   = plint_pkg::RST_S2;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset curve: breakpoints, their neighbors, both ends of the sample range
    sample_q = '{16'd0, 16'd1, 16'd30, 16'd59, 16'd60, 16'd61, 16'd280,
                 16'd499, 16'd500, 16'd501, 16'hFFFF};
    wait_drained();

    // empty curve
    set_curve(2'd0, 16'd10, 16'd20, 16'd30, 24'h010000, 24'h020000, 24'h030000);
    sample_q = '{16'd0, 16'hFFFF};
    wait_drained();

    // single breakpoint, most negative score
    set_curve(2'd1, 16'd1000, 16'd5, 16'd7, 24'h800000, 24'h7FFFFF, 24'h000001);
    sample_q = '{16'd0, 16'd1000, 16'hFFFF};
    wait_drained();

    // one segment spanning the full range, score swings end to end
    set_curve(2'd2, 16'd0, 16'hFFFF, 16'd0, 24'h800000, 24'h7FFFFF, 24'h000000);
    sample_q = '{16'd1, 16'h8000, 16'hFFFE};
    wait_drained();

    // unordered breakpoints
    set_curve(2'd3, 16'd300, 16'd100, 16'd200, 24'h7FFFFF, 24'hFF0000, 24'h800000);
    sample_q = '{16'd150, 16'd250, 16'd300, 16'd100};
    wait_drained();

    // steep swings, last point at the top of the range
    set_curve(2'd3, 16'd10, 16'd20, 16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    sample_q = '{16'd15, 16'hFFFF};
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      random_curve();
      calm = (p == 3);
      random_samples(58);
      wait_drained();
      calm = 1'b0;
    end

    repeat (TAIL_WAIT) @(posedge clk_i);
    if (error_count == 0 && score_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
